FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is active.
`define BVCD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bvcd assertion failed");

// Clocked assertion that also holds during reset.
`define BVCD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bvcd assertion failed");

`endif

FILE: rtl/core/bvcd_pkg.sv
// Types, constants and tables for the ball velocity change detector.
`timescale 1ns / 1ps
package bvcd_pkg;

    localparam int MAG_W    = 25;   // floor(sqrt(d2 * 65536))
    localparam int SQ_W     = 34;   // dx*dx + dy*dy
    localparam int RAD_W    = 50;   // radicand, SQ_W + 16
    localparam int QUO_W    = 37;   // speed and dividend
    localparam int CORD_W   = 34;   // CORDIC x, y
    localparam int MULB_W   = 20;
    localparam int PROD_W   = MAG_W + MULB_W;
    localparam logic [MULB_W-1:0] SPEED_SCALE = 20'd1000000;
    localparam logic [3:0] CORDIC_STEPS = 4'd15;

    localparam logic [15:0] SPEED_THR_RST = 16'd1000;
    localparam logic [15:0] ANGLE_THR_RST = 16'd1820;
    localparam logic [15:0] QUARTER_TURN  = 16'h4000;
    localparam logic [15:0] HALF_TURN     = 16'h8000;

    typedef enum logic [0:0] {
        CFG_SPEED_THR = 1'b0,
        CFG_ANGLE_THR = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_DECIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        capture_time;
    } t_in;

    typedef struct packed {
        logic kick_start;
        logic history_ready;
    } t_out;

    // Arctangent of 2^-i in 1/65536 turn, rounded.
    function automatic logic [15:0] atan_bam(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            4'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/ball_velocity_change_detector.sv
// Top level of the ball velocity change detector.
//
// Input channel (i_in_valid / o_in_ready) takes one ball observation a beat:
// position in mm and capture time in us. Output channel (o_out_valid /
// i_out_ready) gives one beat per observation: kick_start and history_ready.
// Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, the block itself does not enforce it.
//
// One observation is worked on at a time; o_in_ready is high only while idle.
// Until three observations are held, or when a time step is not positive, the
// result skips the arithmetic and goes to the output register. Otherwise each
// of the two segments runs through one shared multiplier, a 25-step
// digit-by-digit square root (with the 15-step CORDIC beside it) and a 37-step
// restoring divider. The output register parts the two sides: a new beat is
// accepted while the last result waits; a stalled receiver holds the block
// only at its end.
// Reset empties the history, clears the run flag and restores the
// thresholds to 1000 mm/s and 1820 angle units.
`timescale 1ns / 1ps
module ball_velocity_change_detector import bvcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic signed [15:0] r_hx [3];
    logic signed [15:0] r_hy [3];
    logic [31:0]        r_ht [3];
    logic [1:0]         r_fill;
    logic               r_last;
    logic [15:0]        r_spd_thr, r_ang_thr;

    logic               r_seg;
    logic [5:0]         r_cnt;
    logic signed [16:0] r_dx, r_dy;
    logic [31:0]        r_dt;
    logic [SQ_W-1:0]    r_d2;
    logic [RAD_W-1:0]   r_rad;
    logic [27:0]        r_rem;
    logic [MAG_W-1:0]   r_root;
    logic [QUO_W-1:0]   r_num;
    logic [31:0]        r_drem;
    logic signed [CORD_W-1:0] r_cx, r_cy;
    logic [15:0]        r_ang;
    logic [3:0]         r_ccnt;
    logic               r_czero;
    logic [QUO_W-1:0]   r_spd0;
    logic [15:0]        r_ang0;
    logic               r_res_kick, r_res_ready;
    logic               r_out_valid;
    t_out               r_out;

    logic accept, out_load;
    assign accept   = i_in_valid && o_in_ready;
    assign out_load = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);

    // Segment operands
    logic signed [15:0] hx_a, hx_b, hy_a, hy_b;
    logic [31:0]        ht_a, ht_b;
    assign hx_a = r_seg ? r_hx[2] : r_hx[1];
    assign hx_b = r_seg ? r_hx[1] : r_hx[0];
    assign hy_a = r_seg ? r_hy[2] : r_hy[1];
    assign hy_b = r_seg ? r_hy[1] : r_hy[0];
    assign ht_a = r_seg ? r_ht[2] : r_ht[1];
    assign ht_b = r_seg ? r_ht[1] : r_ht[0];

    logic time_ok;
    assign time_ok = (r_ht[1] > r_ht[0]) && (r_ht[2] > r_ht[1]);

    // Shared multiplier
    logic [16:0]        dx_abs, dy_abs;
    logic [MAG_W-1:0]   mul_a;
    logic [MULB_W-1:0]  mul_b;
    logic [PROD_W-1:0]  prod;
    logic [SQ_W-1:0]    sq_sum;
    assign dx_abs = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
    assign dy_abs = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);

    always_comb begin
        case (r_state)
            ST_SQX: begin
                mul_a = {8'd0, dx_abs};
                mul_b = {3'd0, dx_abs};
            end
            ST_SQY: begin
                mul_a = {8'd0, dy_abs};
                mul_b = {3'd0, dy_abs};
            end
            default: begin
                mul_a = r_root;
                mul_b = SPEED_SCALE;
            end
        endcase
    end
    assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign sq_sum = r_d2 + prod[SQ_W-1:0];

    // Square root step
    logic [27:0] rem_sh;
    logic [26:0] trial;
    logic        sq_ge;
    assign rem_sh = {r_rem[25:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign sq_ge  = rem_sh >= {1'b0, trial};

    // Divider step
    logic [32:0] dr;
    logic [32:0] dsub;
    logic        dv_ge;
    assign dr    = {r_drem, r_num[QUO_W-1]};
    assign dsub  = dr - {1'b0, r_dt};
    assign dv_ge = dr >= {1'b0, r_dt};

    // CORDIC step
    logic signed [CORD_W-1:0] xs, ys, dxs, dys;
    assign xs  = r_cx >>> r_ccnt;
    assign ys  = r_cy >>> r_ccnt;
    assign dxs = CORD_W'(r_dx) <<< 14;
    assign dys = CORD_W'(r_dy) <<< 14;

    // Decision
    logic [15:0]      cur_ang, ad, adf;
    logic [QUO_W-1:0] sdiff;
    logic             det;
    assign cur_ang = r_czero ? 16'd0 : r_ang;
    assign ad      = cur_ang - r_ang0;
    assign adf     = (ad > HALF_TURN) ? 16'(16'd0 - ad) : ad;
    assign sdiff   = (r_num >= r_spd0) ? (r_num - r_spd0) : (r_spd0 - r_num);
    assign det     = (sdiff > QUO_W'(r_spd_thr)) || (adf > r_ang_thr);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_fill != 2'd3 || !time_ok) n_state = ST_FINISH;
                else                            n_state = ST_LOAD;
            end
            ST_LOAD:  n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == 6'd0) n_state = ST_MUL;
            end
            ST_MUL:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 6'd0) n_state = ST_STORE;
            end
            ST_STORE: n_state = r_seg ? ST_DECIDE : ST_LOAD;
            ST_DECIDE: n_state = ST_FINISH;
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 2'd0;
            r_last      <= 1'b0;
            r_spd_thr   <= SPEED_THR_RST;
            r_ang_thr   <= ANGLE_THR_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SPEED_THR: r_spd_thr <= i_cfg_data;
                    CFG_ANGLE_THR: r_ang_thr <= i_cfg_data;
                    default:       r_spd_thr <= r_spd_thr;
                endcase
            end
            if (accept && r_fill != 2'd3) r_fill <= r_fill + 2'd1;
            if (r_state == ST_CHECK && r_fill == 2'd3 && !time_ok) r_last <= 1'b0;
            if (r_state == ST_DECIDE) r_last <= det && !r_last;
            if (out_load)                      r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hx[0] <= r_hx[1];
            r_hy[0] <= r_hy[1];
            r_ht[0] <= r_ht[1];
            r_hx[1] <= r_hx[2];
            r_hy[1] <= r_hy[2];
            r_ht[1] <= r_ht[2];
            r_hx[2] <= i_in_data.pos_x;
            r_hy[2] <= i_in_data.pos_y;
            r_ht[2] <= i_in_data.capture_time;
        end
        if (out_load) begin
            r_out.kick_start    <= r_res_kick;
            r_out.history_ready <= r_res_ready;
        end
        case (r_state)
            ST_CHECK: begin
                r_res_kick  <= 1'b0;
                r_res_ready <= (r_fill == 2'd3);
                r_seg       <= 1'b0;
            end
            ST_LOAD: begin
                r_dx <= 17'(hx_a) - 17'(hx_b);
                r_dy <= 17'(hy_a) - 17'(hy_b);
                r_dt <= ht_a - ht_b;
            end
            ST_SQX: r_d2 <= prod[SQ_W-1:0];
            ST_SQY: begin
                r_rad   <= {sq_sum, 16'd0};
                r_rem   <= 28'd0;
                r_root  <= '0;
                r_cnt   <= 6'(MAG_W - 1);
                r_ccnt  <= 4'd0;
                r_czero <= (r_dx == 17'sd0) && (r_dy == 17'sd0);
                if (r_dx[16]) begin
                    if (!r_dy[16]) begin
                        r_cx  <= dys;
                        r_cy  <= -dxs;
                        r_ang <= QUARTER_TURN;
                    end else begin
                        r_cx  <= -dys;
                        r_cy  <= dxs;
                        r_ang <= 16'(16'd0 - QUARTER_TURN);
                    end
                end else begin
                    r_cx  <= dxs;
                    r_cy  <= dys;
                    r_ang <= 16'd0;
                end
            end
            ST_SQRT: begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                if (sq_ge) begin
                    r_rem  <= rem_sh - {1'b0, trial};
                    r_root <= {r_root[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                // CORDIC runs beside the root loop and finishes first
                if (r_ccnt != CORDIC_STEPS) begin
                    if (!r_cy[CORD_W-1]) begin
                        r_cx  <= r_cx + ys;
                        r_cy  <= r_cy - xs;
                        r_ang <= r_ang + atan_bam(r_ccnt);
                    end else begin
                        r_cx  <= r_cx - ys;
                        r_cy  <= r_cy + xs;
                        r_ang <= r_ang - atan_bam(r_ccnt);
                    end
                    r_ccnt <= r_ccnt + 4'd1;
                end
            end
            ST_MUL: begin
                r_num  <= prod[PROD_W-1:8];
                r_drem <= 32'd0;
                r_cnt  <= 6'(QUO_W - 1);
            end
            ST_DIV: begin
                r_drem <= dv_ge ? dsub[31:0] : dr[31:0];
                r_num  <= {r_num[QUO_W-2:0], dv_ge};
                r_cnt  <= r_cnt - 6'd1;
            end
            ST_STORE: begin
                if (!r_seg) begin
                    r_spd0 <= r_num;
                    r_ang0 <= cur_ang;
                    r_seg  <= 1'b1;
                end
            end
            ST_DECIDE: begin
                r_res_kick  <= det && !r_last;
                r_res_ready <= 1'b1;
            end
            default: begin
                r_seg <= r_seg;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/bvcd_checker.sv
// Port checker for the ball velocity change detector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bvcd_checker import bvcd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic r_prev_kick;

    // Track the kick flag of the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_kick <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_prev_kick <= o_out_data.kick_start;
        end
    end

    `BVCD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `BVCD_ASSERT(a_kick_needs_history, i_clk, i_rst_n, (o_out_valid && o_out_data.kick_start) |-> o_out_data.history_ready)
    `BVCD_ASSERT(a_no_back_to_back_kick, i_clk, i_rst_n, (o_out_valid && r_prev_kick) |-> !o_out_data.kick_start)
    `BVCD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
    `BVCD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready))

endmodule

bind ball_velocity_change_detector bvcd_checker u_bvcd_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for the ball velocity change detector.
`timescale 1ns / 1ps
module testbench;
    import bvcd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = CFG_SPEED_THR;
    logic [15:0] i_cfg_data = '0;

    ball_velocity_change_detector u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    logic [15:0] thr_speed, thr_angle;
    logic signed [15:0] hx [3];
    logic signed [15:0] hy [3];
    logic [31:0] ht [3];
    int unsigned fill;
    bit  run_flag;

    t_in  obs_queue[$];
    t_out kick_queue[$];
    int   errors = 0;
    bit   gate_send = 1'b1;
    bit   hold_out = 1'b0;
    int   long_hold = 0;

    function automatic longint asr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] heading(longint dx, longint dy);
        longint x, y, t, xs, ys;
        int acc;
        int tbl [15];
        tbl = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        acc = 0;
        if (dx == 0 && dy == 0) return 16'd0;
        x = dx * 16384;
        y = dy * 16384;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = 16384;
            end else begin
                t = x; x = -y; y = t; acc = -16384;
            end
        end
        for (int i = 0; i < 15; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += tbl[i];
            end else begin
                x = x - ys; y = y + xs; acc -= tbl[i];
            end
        end
        return acc[15:0];
    endfunction

    function automatic longint unsigned seg_rate(longint dx, longint dy, logic [31:0] dt);
        longint unsigned d2, mag;
        d2 = dx * dx + dy * dy;
        mag = root64(d2 << 16);
        return (mag * 64'd1000000) / ({32'd0, dt} * 64'd256);
    endfunction

    function automatic bit velocity_jump();
        longint dx1, dy1, dx2, dy2;
        longint unsigned s1, s2, sd;
        logic [15:0] ad;
        if (ht[1] <= ht[0] || ht[2] <= ht[1]) return 1'b0;
        dx1 = longint'(hx[1]) - hx[0];
        dy1 = longint'(hy[1]) - hy[0];
        dx2 = longint'(hx[2]) - hx[1];
        dy2 = longint'(hy[2]) - hy[1];
        s1 = seg_rate(dx1, dy1, ht[1] - ht[0]);
        s2 = seg_rate(dx2, dy2, ht[2] - ht[1]);
        sd = s2 > s1 ? s2 - s1 : s1 - s2;
        ad = heading(dx2, dy2) - heading(dx1, dy1);
        if (ad > HALF_TURN) ad = 16'd0 - ad;
        return sd > thr_speed || ad > thr_angle;
    endfunction

    function automatic t_out predict_kick(t_in b);
        t_out r;
        r = '0;
        hx[0] = hx[1]; hy[0] = hy[1]; ht[0] = ht[1];
        hx[1] = hx[2]; hy[1] = hy[2]; ht[1] = ht[2];
        hx[2] = b.pos_x; hy[2] = b.pos_y; ht[2] = b.capture_time;
        if (fill < 3) fill++;
        if (fill >= 3) begin
            r.history_ready = 1'b1;
            if (velocity_jump()) r.kick_start = !run_flag;
            run_flag = r.kick_start;
        end
        return r;
    endfunction

    // Driver: bursts with random gaps
    int gap = 0, burst = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                kick_queue = {kick_queue, predict_kick(i_in_data)};
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_in_valid <= 1'b0;
                end else if (gate_send && obs_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= obs_queue.pop_front();
                    if (burst > 0) burst <= burst - 1;
                    else begin
                        burst <= $urandom_range(0, 12);
                        gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern and long hold
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            i_out_ready <= 1'b0;
        end else if (hold_out) begin
            long_hold <= 3000;
            i_out_ready <= 1'b0;
        end else if (stall_phase[9]) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (kick_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, actual %p", $time, o_out_data);
            end else begin
                if (o_out_data.kick_start !== kick_queue[0].kick_start) begin
                    errors++;
                    $display("%0t: kick_start expected %b actual %b", $time,
                             kick_queue[0].kick_start, o_out_data.kick_start);
                end
                if (o_out_data.history_ready !== kick_queue[0].history_ready) begin
                    errors++;
                    $display("%0t: history_ready expected %b actual %b", $time,
                             kick_queue[0].history_ready, o_out_data.history_ready);
                end
                void'(kick_queue.pop_front());
            end
        end
    end

    task automatic drain();
        while (obs_queue.size() > 0 || i_in_valid || kick_queue.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SPEED_THR) thr_speed = val;
        else thr_angle = val;
    endtask

    function automatic void add_obs(logic [15:0] x, logic [15:0] y, logic [31:0] t);
        t_in b;
        b.pos_x = x; b.pos_y = y; b.capture_time = t;
        obs_queue = {obs_queue, b};
    endfunction

    // Mostly smooth tracks with occasional kicks, time jumps and noise
    task automatic add_track(int n);
        int x, y, vx, vy;
        logic [31:0] t;
        x = $urandom_range(0, 65535) - 32768;
        y = $urandom_range(0, 65535) - 32768;
        vx = $urandom_range(0, 400) - 200;
        vy = $urandom_range(0, 400) - 200;
        t = $urandom;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: begin vx = $urandom_range(0, 800) - 400; vy = $urandom_range(0, 800) - 400; end
                1: t = t - $urandom_range(0, 5000);
                2: add_obs(16'($urandom), 16'($urandom), $urandom);
                default: ;
            endcase
            x += vx; y += vy;
            t += $urandom_range(1, 20000);
            if ($urandom_range(0, 3) == 0) begin
                x += $urandom_range(0, 6) - 3;
                y += $urandom_range(0, 6) - 3;
            end
            add_obs(x[15:0], y[15:0], t);
        end
    endtask

    initial begin
        thr_speed = SPEED_THR_RST;
        thr_angle = ANGLE_THR_RST;
        for (int i = 0; i < 3; i++) begin hx[i] = 0; hy[i] = 0; ht[i] = 0; end
        fill = 0;
        run_flag = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, zero motion, zero and backward time steps
        add_obs(16'h8000, 16'h8000, 32'd0);
        add_obs(16'h7fff, 16'h7fff, 32'd1);
        add_obs(16'h8000, 16'h7fff, 32'hffffffff);
        add_obs(16'h8000, 16'h7fff, 32'hffffffff);
        add_obs(16'h0000, 16'h0000, 32'd100);
        add_obs(16'h0000, 16'h0000, 32'd200);
        add_obs(16'h0000, 16'h0000, 32'd300);
        add_obs(16'd100, 16'd0, 32'd400);
        add_obs(16'd200, 16'd0, 32'd500);
        add_obs(16'd200, 16'd100, 32'd600);
        add_obs(16'd200, 16'd200, 32'd700);
        add_obs(16'd100, 16'd200, 32'd800);
        add_obs(16'hff00, 16'hff00, 32'd900);
        add_obs(16'h7fff, 16'h8000, 32'd901);
        add_obs(16'h8000, 16'h8000, 32'd902);
        drain();

        write_reg(CFG_SPEED_THR, 16'd0);
        write_reg(CFG_ANGLE_THR, 16'd0);
        add_track(20);
        drain();
        write_reg(CFG_SPEED_THR, 16'hffff);
        write_reg(CFG_ANGLE_THR, 16'd32768);
        add_track(20);
        drain();

        // Fill the block while the receiver is held off
        hold_out = 1'b1;
        add_track(10);
        repeat (2) @(posedge i_clk);
        hold_out = 1'b0;
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_SPEED_THR, 16'($urandom_range(0, 4000)));
            write_reg(CFG_ANGLE_THR, (ph == 3) ? 16'd32767 : 16'($urandom_range(0, 5000)));
            for (int k = 0; k < 11; k++) add_track($urandom_range(3, 30));
            if (ph == 2) begin
                // let some beats through, then pause the sender until all results are back
                repeat (2000) @(posedge i_clk);
                gate_send = 1'b0;
                while (kick_queue.size() > 0 || i_in_valid) @(posedge i_clk);
                gate_send = 1'b1;
            end
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bvcd_pkg.sv
rtl/core/ball_velocity_change_detector.sv
rtl/core/bvcd_checker.sv
bench/testbench.sv
